>>> rtl/maze_backtracker_step_core_macros.svh
// Assertion macros shared by the maze carver RTL.
`ifndef MAZE_BACKTRACKER_STEP_CORE_MACROS_SVH
`define MAZE_BACKTRACKER_STEP_CORE_MACROS_SVH

// Concurrent check sampled on clk_i, off while rst_ni is low.
`define MBS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Antecedent in one cycle, consequent in the next.
`define MBS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/mbs_pkg.sv
// Shared types and constants of the maze carver.
package mbs_pkg;

  // Grid limits; a cell index is {row, col}, so both stay powers of two.
  localparam int MaxRows = 32;
  localparam int MaxCols = 32;
  localparam int RowW    = $clog2(MaxRows);
  localparam int ColW    = $clog2(MaxCols);
  localparam int CellW   = RowW + ColW;
  localparam int Cells   = MaxRows * MaxCols;
  localparam int CntW    = $clog2(Cells + 1);

  localparam int DimW    = 6;
  localparam int RndW    = 8;
  localparam int MoveW   = 3;
  localparam int CfgIdxW = 1;

  localparam int InTdataW  = ((RowW + ColW + RndW + 7) / 8) * 8;
  localparam int OutTdataW = ((RowW + ColW + MoveW + 7) / 8) * 8;

  localparam logic [3:0] WallNorth = 4'h8;
  localparam logic [3:0] WallEast  = 4'h4;
  localparam logic [3:0] WallSouth = 4'h2;
  localparam logic [3:0] WallWest  = 4'h1;
  localparam logic [3:0] WallAll   = 4'hF;

  typedef enum logic [MoveW-1:0] {
    MoveNorth = 3'd0,
    MoveSouth = 3'd1,
    MoveEast  = 3'd2,
    MoveWest  = 3'd3,
    MoveBack  = 3'd4,
    MoveIdle  = 3'd5
  } move_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgGridWidth  = 1'b0,
    CfgGridHeight = 1'b1
  } cfg_idx_e;

  // Wall map read slots; the four neighbors keep candidate order.
  typedef enum logic [2:0] {
    SlotWest  = 3'd0,
    SlotEast  = 3'd1,
    SlotNorth = 3'd2,
    SlotSouth = 3'd3,
    SlotHere  = 3'd4
  } slot_e;

  typedef struct packed {
    logic  in_ready;
    logic  clr_step;
    logic  wall_rd;
    slot_e rd_slot;
    logic  stk_rd;
    logic  eval;
    logic  wr_here;
    logic  wr_nb;
    logic  out_load;
  } cmd_t;

  typedef struct packed {
    logic in_valid;
    logic start_req;
    logic stack_empty;
    logic clr_last;
    logic has_cand;
    logic out_free;
  } status_t;

endpackage

>>> rtl/mbs_ctrl.sv
// Sequencer of the maze carver: map sweep, neighbor reads, carve or pop, result hand-off.
module mbs_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  mbs_pkg::status_t status_i,
  output mbs_pkg::cmd_t    cmd_o
);

  typedef enum logic [3:0] {
    StClear,
    StIdle,
    StRdHere,
    StRdWest,
    StRdEast,
    StRdNorth,
    StRdSouth,
    StCapture,
    StEval,
    StWrHere,
    StWrNb,
    StFinish
  } state_e;

  state_e state_q, state_d;
  logic   start_pend_q, start_pend_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StClear;
      start_pend_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      start_pend_q <= start_pend_d;
    end
  end

  always_comb begin
    state_d      = state_q;
    start_pend_d = start_pend_q;
    cmd_o        = '0;
    cmd_o.rd_slot = mbs_pkg::SlotHere;
    unique case (state_q)
      StClear: begin
        cmd_o.clr_step = 1'b1;
        if (status_i.clr_last) begin
          state_d      = start_pend_q ? StFinish : StIdle;
          start_pend_d = 1'b0;
        end
      end
      StIdle: begin
        cmd_o.in_ready = 1'b1;
        if (status_i.in_valid) begin
          start_pend_d = status_i.start_req;
          if (status_i.start_req) begin
            state_d = StClear;
          end else if (status_i.stack_empty) begin
            state_d = StFinish;
          end else begin
            state_d = StRdHere;
          end
        end
      end
      StRdHere: begin
        cmd_o.wall_rd = 1'b1;
        cmd_o.rd_slot = mbs_pkg::SlotHere;
        cmd_o.stk_rd  = 1'b1;
        state_d       = StRdWest;
      end
      StRdWest: begin
        cmd_o.wall_rd = 1'b1;
        cmd_o.rd_slot = mbs_pkg::SlotWest;
        state_d       = StRdEast;
      end
      StRdEast: begin
        cmd_o.wall_rd = 1'b1;
        cmd_o.rd_slot = mbs_pkg::SlotEast;
        state_d       = StRdNorth;
      end
      StRdNorth: begin
        cmd_o.wall_rd = 1'b1;
        cmd_o.rd_slot = mbs_pkg::SlotNorth;
        state_d       = StRdSouth;
      end
      StRdSouth: begin
        cmd_o.wall_rd = 1'b1;
        cmd_o.rd_slot = mbs_pkg::SlotSouth;
        state_d       = StCapture;
      end
      StCapture: begin
        // last mask lands in the datapath this cycle
        state_d = StEval;
      end
      StEval: begin
        cmd_o.eval = 1'b1;
        state_d    = status_i.has_cand ? StWrHere : StFinish;
      end
      StWrHere: begin
        cmd_o.wr_here = 1'b1;
        state_d       = StWrNb;
      end
      StWrNb: begin
        cmd_o.wr_nb = 1'b1;
        state_d     = StFinish;
      end
      StFinish: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

endmodule

>>> rtl/mbs_datapath.sv
// Datapath of the maze carver: config, wall map, trail stack, position and result register.
module mbs_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [mbs_pkg::CfgIdxW-1:0]         cfg_index_i,
  input  logic [mbs_pkg::DimW-1:0]            cfg_data_i,
  input  logic                                s_axis_tvalid,
  input  logic [mbs_pkg::InTdataW-1:0]        s_axis_tdata,
  input  logic                                s_axis_tuser,
  input  logic                                m_axis_tready,
  output logic                                m_axis_tvalid,
  output logic [mbs_pkg::OutTdataW-1:0]       m_axis_tdata,
  output logic                                m_axis_tlast,
  input  mbs_pkg::cmd_t                       cmd_i,
  output mbs_pkg::status_t                    status_o
);

  localparam int RowW  = mbs_pkg::RowW;
  localparam int ColW  = mbs_pkg::ColW;
  localparam int CellW = mbs_pkg::CellW;
  localparam int CntW  = mbs_pkg::CntW;
  localparam int DimW  = mbs_pkg::DimW;
  localparam int RndW  = mbs_pkg::RndW;
  localparam int PadW  = mbs_pkg::OutTdataW - (RowW + ColW + mbs_pkg::MoveW);

  // 8-bit value mod 3: base-4 digits sum to the same residue.
  function automatic logic [1:0] mod3_u8(input logic [7:0] v);
    logic [3:0] s;
    logic [2:0] t;
    s = 4'(v[1:0]) + 4'(v[3:2]) + 4'(v[5:4]) + 4'(v[7:6]);
    t = 3'(s[1:0]) + 3'(s[3:2]);
    if (t >= 3'd3) t = t - 3'd3;
    if (t >= 3'd3) t = t - 3'd3;
    return t[1:0];
  endfunction

  // k-th set flag, counting from west.
  function automatic mbs_pkg::slot_e pick_slot(input logic [3:0] cand, input logic [1:0] k);
    logic [2:0] seen;
    mbs_pkg::slot_e sel;
    seen = 3'd0;
    sel  = mbs_pkg::SlotWest;
    for (int i = 0; i < 4; i++) begin
      if (cand[i]) begin
        if (seen == {1'b0, k}) sel = mbs_pkg::slot_e'(3'(i));
        seen = seen + 3'd1;
      end
    end
    return sel;
  endfunction

  // ---------------- configuration ----------------
  logic [DimW-1:0] grid_width_q, grid_height_q;
  logic [DimW-1:0] eff_w, eff_h;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_width_q  <= DimW'(10);
      grid_height_q <= DimW'(10);
    end else if (cfg_we_i) begin
      unique case (mbs_pkg::cfg_idx_e'(cfg_index_i))
        mbs_pkg::CfgGridWidth:  grid_width_q  <= cfg_data_i;
        mbs_pkg::CfgGridHeight: grid_height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (grid_width_q == '0) eff_w = DimW'(1);
    else if (grid_width_q > DimW'(mbs_pkg::MaxCols)) eff_w = DimW'(mbs_pkg::MaxCols);
    else eff_w = grid_width_q;
    if (grid_height_q == '0) eff_h = DimW'(1);
    else if (grid_height_q > DimW'(mbs_pkg::MaxRows)) eff_h = DimW'(mbs_pkg::MaxRows);
    else eff_h = grid_height_q;
  end

  // ---------------- request fields ----------------
  logic            accept;
  logic [RowW-1:0] in_row, start_row;
  logic [ColW-1:0] in_col, start_col;
  logic [RndW-1:0] in_rnd;

  assign accept = cmd_i.in_ready & s_axis_tvalid;
  assign in_row = s_axis_tdata[RowW-1:0];
  assign in_col = s_axis_tdata[CellW-1:RowW];
  assign in_rnd = s_axis_tdata[CellW+RndW-1:CellW];

  assign start_row = (DimW'(in_row) < eff_h) ? in_row : RowW'(eff_h - DimW'(1));
  assign start_col = (DimW'(in_col) < eff_w) ? in_col : ColW'(eff_w - DimW'(1));

  // ---------------- state registers ----------------
  logic [RowW-1:0] cur_row_q, nb_row_q;
  logic [ColW-1:0] cur_col_q, nb_col_q;
  logic [CntW-1:0] count_q;
  logic [RndW-1:0] rnd_q;
  mbs_pkg::move_e  move_q;
  logic [3:0]      here_clr_q, nb_wr_q;
  logic [3:0]      masks_q [5];
  logic            cap_pend_q;
  mbs_pkg::slot_e  cap_slot_q;
  logic [CellW-1:0] clr_addr_q;

  // ---------------- wall map (single port) ----------------
  logic [3:0]       wall_mem [mbs_pkg::Cells];
  logic [3:0]       wall_rdata_q;
  logic [CellW-1:0] wall_addr;
  logic [3:0]       wall_wdata;
  logic             wall_we;
  logic [RowW-1:0]  rd_row;
  logic [ColW-1:0]  rd_col;

  always_comb begin
    rd_row = cur_row_q;
    rd_col = cur_col_q;
    case (cmd_i.rd_slot)
      mbs_pkg::SlotWest:  rd_col = cur_col_q - ColW'(1);
      mbs_pkg::SlotEast:  rd_col = cur_col_q + ColW'(1);
      mbs_pkg::SlotNorth: rd_row = cur_row_q - RowW'(1);
      mbs_pkg::SlotSouth: rd_row = cur_row_q + RowW'(1);
      default: ;
    endcase
  end

  always_comb begin
    wall_we    = cmd_i.clr_step | cmd_i.wr_here | cmd_i.wr_nb;
    wall_wdata = mbs_pkg::WallAll;
    wall_addr  = {rd_row, rd_col};
    if (cmd_i.clr_step) begin
      wall_addr = clr_addr_q;
    end else if (cmd_i.wr_here) begin
      wall_addr  = {cur_row_q, cur_col_q};
      wall_wdata = masks_q[mbs_pkg::SlotHere] & ~here_clr_q;
    end else if (cmd_i.wr_nb) begin
      wall_addr  = {nb_row_q, nb_col_q};
      wall_wdata = nb_wr_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wall_we) wall_mem[wall_addr] <= wall_wdata;
    else if (cmd_i.wall_rd) wall_rdata_q <= wall_mem[wall_addr];
  end

  // ---------------- trail stack ----------------
  logic [CellW-1:0] stk_mem [mbs_pkg::Cells];
  logic [CellW-1:0] stk_rdata_q;
  logic             stk_we;
  logic [CellW-1:0] stk_waddr, stk_wdata, stk_raddr;
  logic             stk_room;

  assign stk_room  = count_q < CntW'(mbs_pkg::Cells);
  assign stk_we    = (accept & s_axis_tuser) | (cmd_i.wr_nb & stk_room);
  assign stk_waddr = cmd_i.wr_nb ? count_q[CellW-1:0] : '0;
  assign stk_wdata = cmd_i.wr_nb ? {nb_row_q, nb_col_q} : {start_row, start_col};
  // entry under the top: the new top after a pop
  assign stk_raddr = CellW'(count_q - CntW'(2));

  always_ff @(posedge clk_i) begin
    if (stk_we) stk_mem[stk_waddr] <= stk_wdata;
    if (cmd_i.stk_rd) stk_rdata_q <= stk_mem[stk_raddr];
  end

  // ---------------- mask capture and sweep ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_pend_q <= 1'b0;
      clr_addr_q <= '0;
    end else begin
      cap_pend_q <= cmd_i.wall_rd;
      if (cmd_i.clr_step) clr_addr_q <= clr_addr_q + CellW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    cap_slot_q <= cmd_i.rd_slot;
    if (cap_pend_q) masks_q[cap_slot_q] <= wall_rdata_q;
  end

  // ---------------- candidate choice ----------------
  logic [DimW-1:0] row_ext, col_ext;
  logic            west_ok, east_ok, north_ok, south_ok;
  logic [3:0]      cand;
  logic [2:0]      n_cand;
  logic [1:0]      k_sel;
  mbs_pkg::slot_e  chosen;

  assign row_ext  = DimW'(cur_row_q);
  assign col_ext  = DimW'(cur_col_q);
  assign west_ok  = (cur_col_q != '0) && (col_ext - DimW'(1) < eff_w) && (row_ext < eff_h);
  assign east_ok  = (col_ext + DimW'(1) < eff_w) && (row_ext < eff_h);
  assign north_ok = (cur_row_q != '0) && (row_ext - DimW'(1) < eff_h) && (col_ext < eff_w);
  assign south_ok = (row_ext + DimW'(1) < eff_h) && (col_ext < eff_w);

  assign cand[0] = west_ok  && (masks_q[mbs_pkg::SlotWest]  == mbs_pkg::WallAll);
  assign cand[1] = east_ok  && (masks_q[mbs_pkg::SlotEast]  == mbs_pkg::WallAll);
  assign cand[2] = north_ok && (masks_q[mbs_pkg::SlotNorth] == mbs_pkg::WallAll);
  assign cand[3] = south_ok && (masks_q[mbs_pkg::SlotSouth] == mbs_pkg::WallAll);
  assign n_cand  = 3'($countones(cand));

  always_comb begin
    case (n_cand)
      3'd1:    k_sel = 2'd0;
      3'd2:    k_sel = {1'b0, rnd_q[0]};
      3'd3:    k_sel = mod3_u8(rnd_q);
      default: k_sel = rnd_q[1:0];
    endcase
  end

  assign chosen = pick_slot(cand, k_sel);

  // ---------------- position, stack count, move ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_row_q <= '0;
      cur_col_q <= '0;
      count_q   <= '0;
    end else if (accept && s_axis_tuser) begin
      cur_row_q <= start_row;
      cur_col_q <= start_col;
      count_q   <= CntW'(1);
    end else if (cmd_i.eval && !(|cand)) begin
      count_q <= count_q - CntW'(1);
      if (count_q != CntW'(1)) begin
        cur_row_q <= stk_rdata_q[CellW-1:ColW];
        cur_col_q <= stk_rdata_q[ColW-1:0];
      end
    end else if (cmd_i.wr_nb) begin
      cur_row_q <= nb_row_q;
      cur_col_q <= nb_col_q;
      if (stk_room) count_q <= count_q + CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rnd_q  <= in_rnd;
      move_q <= mbs_pkg::MoveIdle;
    end else if (cmd_i.eval) begin
      if (!(|cand)) begin
        move_q <= mbs_pkg::MoveBack;
      end else begin
        case (chosen)
          mbs_pkg::SlotWest: begin
            move_q     <= mbs_pkg::MoveWest;
            nb_row_q   <= cur_row_q;
            nb_col_q   <= cur_col_q - ColW'(1);
            here_clr_q <= mbs_pkg::WallWest;
            nb_wr_q    <= mbs_pkg::WallAll & ~mbs_pkg::WallEast;
          end
          mbs_pkg::SlotEast: begin
            move_q     <= mbs_pkg::MoveEast;
            nb_row_q   <= cur_row_q;
            nb_col_q   <= cur_col_q + ColW'(1);
            here_clr_q <= mbs_pkg::WallEast;
            nb_wr_q    <= mbs_pkg::WallAll & ~mbs_pkg::WallWest;
          end
          mbs_pkg::SlotNorth: begin
            move_q     <= mbs_pkg::MoveNorth;
            nb_row_q   <= cur_row_q - RowW'(1);
            nb_col_q   <= cur_col_q;
            here_clr_q <= mbs_pkg::WallNorth;
            nb_wr_q    <= mbs_pkg::WallAll & ~mbs_pkg::WallSouth;
          end
          default: begin
            move_q     <= mbs_pkg::MoveSouth;
            nb_row_q   <= cur_row_q + RowW'(1);
            nb_col_q   <= cur_col_q;
            here_clr_q <= mbs_pkg::WallSouth;
            nb_wr_q    <= mbs_pkg::WallAll & ~mbs_pkg::WallNorth;
          end
        endcase
      end
    end
  end

  // ---------------- result register ----------------
  logic            out_valid_q;
  logic [RowW-1:0] out_row_q;
  logic [ColW-1:0] out_col_q;
  mbs_pkg::move_e  out_move_q;
  logic            out_done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_row_q  <= cur_row_q;
      out_col_q  <= cur_col_q;
      out_move_q <= move_q;
      out_done_q <= (count_q == '0);
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {PadW'(0), out_move_q, out_col_q, out_row_q};
  assign m_axis_tlast  = out_done_q;

  assign status_o.in_valid    = s_axis_tvalid;
  assign status_o.start_req   = s_axis_tuser;
  assign status_o.stack_empty = (count_q == '0);
  assign status_o.clr_last    = &clr_addr_q;
  assign status_o.has_cand    = |cand;
  assign status_o.out_free    = ~out_valid_q | m_axis_tready;

endmodule

>>> rtl/maze_backtracker_step_core.sv
// Top level of the maze carver: sequencer plus datapath.
//
//  channel   dir  payload
//  s_axis    in   tdata: start_row[4:0] start_col[9:5] random_value[17:10]; tuser: start_req
//  m_axis    out  tdata: current_row[4:0] current_col[9:5] move[12:10]; tlast: done_res
//  cfg       in   cfg_we_i, cfg_index_i (0 grid_width, 1 grid_height), cfg_data_i
//
// One request at a time; the wall map has one port, so a carve runs through
// five map reads, capture, decide, two map writes and result load, a pop skips
// the writes, an advance on an empty trail goes straight to result load. A start
// rewrites all 1024 map cells, one a cycle. After reset the same map sweep runs
// before the first request is taken. A held result stalls only the load of the
// next one; the request after it is still taken while the result register is full.
`include "maze_backtracker_step_core_macros.svh"

module maze_backtracker_step_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [mbs_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [mbs_pkg::DimW-1:0]      cfg_data_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // start_row[4:0], start_col[9:5], random_value[17:10], zero pad
  input  logic [mbs_pkg::InTdataW-1:0]  s_axis_tdata,
  // start_req
  input  logic                          s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // current_row[4:0], current_col[9:5], move[12:10], zero pad
  output logic [mbs_pkg::OutTdataW-1:0] m_axis_tdata,
  output logic                          m_axis_tlast
);

  mbs_pkg::cmd_t    cmd;
  mbs_pkg::status_t status;

  mbs_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .cmd_o    (cmd)
  );

  mbs_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tready (m_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cmd_i         (cmd),
    .status_o      (status)
  );

  assign s_axis_tready = cmd.in_ready;

  `MBS_ASSERT_NEXT(a_busy_after_req, s_axis_tvalid && s_axis_tready, !s_axis_tready, "request taken while busy")
  `MBS_ASSERT(a_load_when_free, cmd.out_load |-> status.out_free, "result register overwritten")
  `MBS_ASSERT(a_done_move, m_axis_tvalid && m_axis_tlast |-> (m_axis_tdata[12:10] == mbs_pkg::MoveBack || m_axis_tdata[12:10] == mbs_pkg::MoveIdle), "done with a carve move")

endmodule

>>> tb/tb_maze_backtracker_step_core.sv
// Self-checking testbench for the maze carver: directed table, then random maze runs.
`timescale 1ns / 100ps

module tb_maze_backtracker_step_core;
  import mbs_pkg::*;

  localparam int RandItems  = 400;
  localparam int StallLimit = 6000;  // start sweep + long receiver hold, taken ~4x
  localparam int HoldCycles = 300;
  localparam int DirN       = 27;

  typedef struct packed {
    logic [RowW-1:0] row;
    logic [ColW-1:0] col;
    move_e           mv;
    logic            done;
  } maze_res_t;

  typedef enum logic [1:0] {
    RowAdv,
    RowStart,
    RowCfg
  } row_kind_e;

  typedef struct packed {
    row_kind_e       kind;
    cfg_idx_e        reg_idx;
    logic [DimW-1:0] reg_val;
    logic [RowW-1:0] row;
    logic [ColW-1:0] col;
    logic [RndW-1:0] rnd;
    logic            typed;
    maze_res_t       res;
  } dir_row_t;

  localparam maze_res_t NoRes = '{5'd0, 5'd0, MoveNorth, 1'b0};

  localparam dir_row_t DirTab [DirN] = '{
    // empty trail right after reset
    '{RowAdv,   CfgGridWidth,  6'd0,  5'd0,  5'd0,  8'd0,   1'b1, '{5'd0, 5'd0, MoveIdle, 1'b1}},
    // start outside the 10x10 grid clamps to the far corner
    '{RowStart, CfgGridWidth,  6'd0,  5'd31, 5'd31, 8'd0,   1'b1, '{5'd9, 5'd9, MoveIdle, 1'b0}},
    '{RowAdv,   CfgGridWidth,  6'd0,  5'd31, 5'd31, 8'd0,   1'b0, NoRes},
    '{RowAdv,   CfgGridWidth,  6'd0,  5'd17, 5'd3,  8'd255, 1'b0, NoRes},
    '{RowAdv,   CfgGridWidth,  6'd0,  5'd0,  5'd0,  8'd128, 1'b0, NoRes},
    // zero size counts as one
    '{RowCfg,   CfgGridWidth,  6'd0,  5'd0,  5'd0,  8'd0,   1'b0, NoRes},
    '{RowCfg,   CfgGridHeight, 6'd0,  5'd0,  5'd0,  8'd0,   1'b0, NoRes},
    '{RowStart, CfgGridWidth,  6'd0,  5'd5,  5'd7,  8'h5a,  1'b1, '{5'd0, 5'd0, MoveIdle, 1'b0}},
    '{RowAdv,   CfgGridWidth,  6'd0,  5'd0,  5'd0,  8'd0,   1'b1, '{5'd0, 5'd0, MoveBack, 1'b1}},
    '{RowAdv,   CfgGridWidth,  6'd0,  5'd0,  5'd0,  8'd0,   1'b1, '{5'd0, 5'd0, MoveIdle, 1'b1}},
    // oversize saturates to 32x32
    '{RowCfg,   CfgGridWidth,  6'd63, 5'd0,  5'd0,  8'd0,   1'b0, NoRes},
    '{RowCfg,   CfgGridHeight, 6'd63, 5'd0,  5'd0,  8'd0,   1'b0, NoRes},
    '{RowStart, CfgGridWidth,  6'd0,  5'd31, 5'd31, 8'd0,   1'b1, '{5'd31, 5'd31, MoveIdle, 1'b0}},
    '{RowAdv,   CfgGridWidth,  6'd0,  5'd0,  5'd0,  8'd255, 1'b0, NoRes},
    '{RowAdv,   CfgGridWidth,  6'd0,  5'd0,  5'd0,  8'd0,   1'b0, NoRes},
    '{RowAdv,   CfgGridWidth,  6'd0,  5'd0,  5'd0,  8'd1,   1'b0, NoRes},
    // shrink mid-run: current cell left outside, trail unwinds
    '{RowCfg,   CfgGridWidth,  6'd2,  5'd0,  5'd0,  8'd0,   1'b0, NoRes},
    '{RowCfg,   CfgGridHeight, 6'd2,  5'd0,  5'd0,  8'd0,   1'b0, NoRes},
    '{RowAdv,   CfgGridWidth,  6'd0,  5'd0,  5'd0,  8'd0,   1'b0, NoRes},
    '{RowAdv,   CfgGridWidth,  6'd0,  5'd0,  5'd0,  8'd85,  1'b0, NoRes},
    '{RowAdv,   CfgGridWidth,  6'd0,  5'd0,  5'd0,  8'd170, 1'b0, NoRes},
    '{RowAdv,   CfgGridWidth,  6'd0,  5'd0,  5'd0,  8'd3,   1'b0, NoRes},
    '{RowCfg,   CfgGridWidth,  6'd33, 5'd0,  5'd0,  8'd0,   1'b0, NoRes},
    '{RowCfg,   CfgGridHeight, 6'd1,  5'd0,  5'd0,  8'd0,   1'b0, NoRes},
    '{RowStart, CfgGridWidth,  6'd0,  5'd0,  5'd0,  8'd0,   1'b1, '{5'd0, 5'd0, MoveIdle, 1'b0}},
    '{RowAdv,   CfgGridWidth,  6'd0,  5'd0,  5'd0,  8'd255, 1'b0, NoRes},
    '{RowAdv,   CfgGridWidth,  6'd0,  5'd0,  5'd0,  8'd7,   1'b0, NoRes}
  };

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 cfg_we_i      = 1'b0;
  logic [CfgIdxW-1:0]   cfg_index_i   = '0;
  logic [DimW-1:0]      cfg_data_i    = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [InTdataW-1:0]  s_axis_tdata  = '0;
  logic                 s_axis_tuser  = 1'b0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [OutTdataW-1:0] m_axis_tdata;
  logic                 m_axis_tlast;

  maze_res_t maze_res_q [$];

  // carving predictor state
  logic [3:0]      wall_q  [Cells];
  int unsigned     trail_q [Cells];
  int unsigned     trail_cnt = 0;
  int unsigned     cur_r     = 0;
  int unsigned     cur_c     = 0;
  logic [DimW-1:0] grid_w_q  = 6'd10;
  logic [DimW-1:0] grid_h_q  = 6'd10;

  bit src_idle_en  = 1'b1;
  bit sink_idle_en = 1'b1;
  int sink_hold_cnt = 0;
  int err_cnt   = 0;
  int n_req     = 0;
  int n_start   = 0;
  int n_res     = 0;
  int n_cfg     = 0;
  int stall_cnt = 0;

  maze_backtracker_step_core u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  function automatic int unsigned grid_span(logic [DimW-1:0] v, int unsigned top);
    if (v == 0) return 1;
    return (v > top) ? top : v;
  endfunction

  function automatic bit cell_sealed(int unsigned r, int unsigned c);
    return wall_q[r * MaxCols + c] == WallAll;
  endfunction

  function automatic logic [DimW-1:0] edge_dim();
    case ($urandom_range(4))
      0: return 6'd0;
      1: return 6'd1;
      2: return 6'd32;
      3: return 6'd63;
      default: return DimW'($urandom_range(33, 62));
    endcase
  endfunction

  task automatic carve_step(input logic st, input logic [RowW-1:0] r,
                            input logic [ColW-1:0] c, input logic [RndW-1:0] rnd,
                            output maze_res_t res);
    int unsigned w, h, n, here;
    move_e cand [4];
    move_e mv;
    logic done;
    w = grid_span(grid_w_q, MaxCols);
    h = grid_span(grid_h_q, MaxRows);
    n = 0;
    mv = MoveIdle;
    done = 1'b0;
    if (st) begin
      foreach (wall_q[i]) wall_q[i] = WallAll;
      cur_r = (r < h) ? r : h - 1;
      cur_c = (c < w) ? c : w - 1;
      trail_q[0] = cur_r * MaxCols + cur_c;
      trail_cnt = 1;
    end else if (trail_cnt == 0) begin
      done = 1'b1;
    end else begin
      // candidate order: west, east, north, south
      if (cur_c > 0 && cur_c - 1 < w && cur_r < h && cell_sealed(cur_r, cur_c - 1)) begin
        cand[n] = MoveWest;
        n++;
      end
      if (cur_c + 1 < w && cur_r < h && cell_sealed(cur_r, cur_c + 1)) begin
        cand[n] = MoveEast;
        n++;
      end
      if (cur_r > 0 && cur_r - 1 < h && cur_c < w && cell_sealed(cur_r - 1, cur_c)) begin
        cand[n] = MoveNorth;
        n++;
      end
      if (cur_r + 1 < h && cur_c < w && cell_sealed(cur_r + 1, cur_c)) begin
        cand[n] = MoveSouth;
        n++;
      end
      if (n == 0) begin
        trail_cnt--;
        if (trail_cnt != 0) begin
          cur_r = trail_q[trail_cnt - 1] / MaxCols;
          cur_c = trail_q[trail_cnt - 1] % MaxCols;
        end
        mv = MoveBack;
        done = (trail_cnt == 0);
      end else begin
        mv = cand[rnd % n];
        here = cur_r * MaxCols + cur_c;
        case (mv)
          MoveNorth: begin
            wall_q[here] &= ~WallNorth;
            cur_r--;
            wall_q[cur_r * MaxCols + cur_c] &= ~WallSouth;
          end
          MoveSouth: begin
            wall_q[here] &= ~WallSouth;
            cur_r++;
            wall_q[cur_r * MaxCols + cur_c] &= ~WallNorth;
          end
          MoveEast: begin
            wall_q[here] &= ~WallEast;
            cur_c++;
            wall_q[cur_r * MaxCols + cur_c] &= ~WallWest;
          end
          default: begin
            wall_q[here] &= ~WallWest;
            cur_c--;
            wall_q[cur_r * MaxCols + cur_c] &= ~WallEast;
          end
        endcase
        // a full trail drops the push
        if (trail_cnt < Cells) begin
          trail_q[trail_cnt] = cur_r * MaxCols + cur_c;
          trail_cnt++;
        end
      end
    end
    res.row  = RowW'(cur_r);
    res.col  = ColW'(cur_c);
    res.mv   = mv;
    res.done = done;
  endtask

  // Offer one request; valid stays high afterwards so back-to-back requests stream.
  task automatic push_request(input logic st, input logic [RowW-1:0] r,
                              input logic [ColW-1:0] c, input logic [RndW-1:0] rnd,
                              input logic typed, input maze_res_t typed_res);
    maze_res_t pred;
    @(negedge clk_i);
    while (src_idle_en && $urandom_range(99) < 17) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= st;
    s_axis_tdata  <= {{(InTdataW - RowW - ColW - RndW){1'b0}}, rnd, c, r};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    carve_step(st, r, c, rnd, pred);
    maze_res_q.push_back(typed ? typed_res : pred);
    n_req++;
    if (st) n_start++;
  endtask

  // Drop valid and wait until every pending result is back.
  task automatic settle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (maze_res_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [DimW-1:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CfgGridWidth) grid_w_q = val;
    else grid_h_q = val;
    n_cfg++;
  endtask

  // receiver: random stalls, plus a single long hold requested by the main flow
  initial begin
    forever begin
      @(negedge clk_i);
      if (sink_hold_cnt > 0) begin
        m_axis_tready <= 1'b0;
        sink_hold_cnt--;
      end else begin
        m_axis_tready <= !(sink_idle_en && $urandom_range(99) < 17);
      end
    end
  end

  always @(posedge clk_i) begin
    maze_res_t got;
    maze_res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.row  = m_axis_tdata[RowW-1:0];
      got.col  = m_axis_tdata[RowW+ColW-1:RowW];
      got.mv   = move_e'(m_axis_tdata[RowW+ColW+MoveW-1:RowW+ColW]);
      got.done = m_axis_tlast;
      n_res++;
      if (maze_res_q.size() == 0) begin
        err_cnt++;
        $error("result with no request pending: row %0d col %0d move %0d",
               got.row, got.col, got.mv);
      end else begin
        want = maze_res_q.pop_front();
        if (got.row !== want.row) begin
          err_cnt++;
          $error("current_row: expected %0d, got %0d", want.row, got.row);
        end
        if (got.col !== want.col) begin
          err_cnt++;
          $error("current_col: expected %0d, got %0d", want.col, got.col);
        end
        if (got.mv !== want.mv) begin
          err_cnt++;
          $error("move: expected %0d, got %0d", want.mv, got.mv);
        end
        if (got.done !== want.done) begin
          err_cnt++;
          $error("done_res: expected %0d, got %0d", want.done, got.done);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cnt = 0;
    end else begin
      stall_cnt++;
      if (stall_cnt >= StallLimit) begin
        $error("no request or result moved for %0d cycles", StallLimit);
        $display("tb_maze_backtracker_step_core failed");
        $finish;
      end
    end
  end

  initial begin
    int unsigned phase;
    int unsigned steps;
    int unsigned span;
    int unsigned n_rand;
    int unsigned pick;
    logic [DimW-1:0] new_w;
    logic [DimW-1:0] new_h;
    bit resume;
    phase  = 0;
    n_rand = 0;
    foreach (wall_q[i]) wall_q[i] = WallAll;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (DirTab[i]) begin
      if (DirTab[i].kind == RowCfg) begin
        settle();
        write_reg(DirTab[i].reg_idx, DirTab[i].reg_val);
      end else begin
        push_request(DirTab[i].kind == RowStart, DirTab[i].row, DirTab[i].col,
                     DirTab[i].rnd, DirTab[i].typed, DirTab[i].res);
      end
    end

    // random maze runs: mostly small grids carved to completion
    while (n_rand < RandItems) begin
      settle();
      src_idle_en  = !(phase >= 4 && phase < 8);
      sink_idle_en = src_idle_en;
      pick = $urandom_range(99);
      if (pick < 55) begin
        new_w = DimW'($urandom_range(2, 5));
        new_h = DimW'($urandom_range(2, 5));
      end else if (pick < 70) begin
        new_w = edge_dim();
        new_h = edge_dim();
      end else begin
        new_w = DimW'($urandom_range(2, 32));
        new_h = DimW'($urandom_range(2, 32));
      end
      if ($urandom_range(3) != 0) write_reg(CfgGridWidth, new_w);
      if ($urandom_range(3) != 0) write_reg(CfgGridHeight, new_h);

      // some phases keep the old maze and only resize the grid
      resume = (phase != 0) && ($urandom_range(4) == 0);
      if (!resume) begin
        push_request(1'b1, RowW'($urandom_range(31)), ColW'($urandom_range(31)),
                     RndW'($urandom_range(255)), 1'b0, NoRes);
        n_rand++;
      end
      if (phase == 2) begin
        // back up the result path while requests keep coming
        settle();
        sink_hold_cnt = HoldCycles;
      end
      span = grid_span(grid_w_q, MaxCols) * grid_span(grid_h_q, MaxRows);
      if (resume) steps = $urandom_range(4, 12);
      else steps = 2 * span + $urandom_range(4);
      if (steps > 60) steps = 60;
      repeat (steps) begin
        push_request($urandom_range(99) < 3, RowW'($urandom_range(31)),
                     ColW'($urandom_range(31)), RndW'($urandom_range(255)), 1'b0, NoRes);
        n_rand++;
      end
      phase++;
    end

    settle();
    repeat (40) @(posedge clk_i);
    $display("Run covered %0d requests (%0d maze restarts) in %0d phases, %0d size writes.",
             n_req, n_start, phase, n_cfg);
    $display("%0d results compared in order, %0d mismatches.", n_res, err_cnt);
    if (err_cnt == 0) begin
      $display("tb_maze_backtracker_step_core passed");
    end else begin
      $display("tb_maze_backtracker_step_core failed");
    end
    $finish;
  end

endmodule

>>> maze_backtracker_step_core.f
+incdir+rtl
rtl/mbs_pkg.sv
rtl/mbs_ctrl.sv
rtl/mbs_datapath.sv
rtl/maze_backtracker_step_core.sv
tb/tb_maze_backtracker_step_core.sv
